FILE: src/slmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmt_pkg
// Shared types and constants of the segment line minimum tree.
// ----------------------------------------------------------------------------
package slmt_pkg;

  // Input item mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Value of a node that holds no line (line 0*x + 9e18)
  localparam logic [63:0] EMPTY_VALUE = 64'd9000000000000000000;

  // Configuration register indexes
  localparam logic REG_DOMAIN_LOW  = 1'b0;
  localparam logic REG_DOMAIN_HIGH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_POP,
    ST_RD,
    ST_LD,
    ST_CA,
    ST_CB,
    ST_CW,
    ST_CD,
    ST_OUT
  } state_e;

  // Which point the shared evaluator works on
  typedef enum logic [1:0] {
    PH_M,
    PH_L,
    PH_R,
    PH_Q
  } phase_e;

endpackage

FILE: src/slmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmt_in_if / slmt_out_if
// Valid/ready channels for items in and results out.
// ----------------------------------------------------------------------------
interface slmt_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] slope;
  logic signed [60:0] intercept;
  logic signed [30:0] seg_lo;
  logic signed [30:0] seg_hi;
  logic signed [30:0] query_x;

  modport source(output valid, mode, slope, intercept, seg_lo, seg_hi, query_x,
                 input ready);
  modport sink(input valid, mode, slope, intercept, seg_lo, seg_hi, query_x,
               output ready);
endinterface

interface slmt_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] min_value;

  modport source(output valid, min_value, input ready);
  modport sink(input valid, min_value, output ready);
endinterface

FILE: src/slmt_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmt_line_mem
// Node line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module slmt_line_mem #(
  parameter int AW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [95:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [95:0]   rdata_o
);

  logic [95:0] mem [2**AW];
  logic [95:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/slmt_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmt_eval_unit
// Shared line evaluator: slope*x + intercept, two register stages, wraps in
// 64 bits.
// ----------------------------------------------------------------------------
module slmt_eval_unit (
  input  logic               clk_i,
  input  logic signed [31:0] k_i,
  input  logic        [63:0] b_i,
  input  logic signed [31:0] x_i,
  output logic        [63:0] value_o
);

  logic signed [63:0] prod_q;
  logic        [63:0] bd_q;
  logic        [63:0] sum_q;

  always_ff @(posedge clk_i) begin
    prod_q <= k_i * x_i;
    bd_q   <= b_i;
    sum_q  <= prod_q + bd_q;
  end

  assign value_o = sum_q;

endmodule

FILE: src/segment_line_min_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_line_min_tree
// Li Chao tree over an integer x domain with segment insert and point
// minimum query.
// ----------------------------------------------------------------------------
// One item at a time. A query visits one node per level. An insert splits down
// to the fully covered nodes and in each one pushes the losing line down the
// push-down path. The pace of both is set by the single shared multiplier-adder
// and the single read port of the node store. After reset and after every
// register write the store is swept back to empty, during which no item is taken.
module segment_line_min_tree #(
  parameter int X_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slmt_in_if.sink     in_i,
  slmt_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slmt_pkg::*;

  localparam int AW = X_BITS + 1;
  localparam int STK_DEPTH = X_BITS + 1;
  localparam int SPW = $clog2(STK_DEPTH + 1);
  localparam int SIW = $clog2(STK_DEPTH);
  localparam logic [32:0] SPAN = (33'd1 << X_BITS) - 33'd1;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [AW-1:0] node_q, node_d, clr_q, clr_d;
  logic signed [31:0] cl_q, cl_d, cr_q, cr_d, lo_q, lo_d, hi_q, hi_d, xq_q, xq_d;
  logic signed [31:0] ik_q, ik_d, ck_q, ck_d, nk_q, nk_d;
  logic [63:0] ib_q, ib_d, cb_q, cb_d, nb_q, nb_d, va_q, va_d, res_q, res_d;
  logic first_q, first_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [30:0] dl_q, dl_d, dh_q, dh_d;
  logic out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic [AW-1:0] stk_node_q [STK_DEPTH];
  logic signed [31:0] stk_l_q [STK_DEPTH];
  logic signed [31:0] stk_r_q [STK_DEPTH];
  logic push;
  logic [AW-1:0] push_node;
  logic signed [31:0] push_l;
  logic [SIW-1:0] top_idx;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [95:0] mem_wdata;
  logic [95:0] mem_rdata;

  logic signed [31:0] ev_k, ev_x;
  logic [63:0] ev_b, ev_val;

  logic cfg_we;
  logic signed [31:0] dl32, dh32, hi_eff, root_r, seg_lo32, seg_hi32, clo, chi, mid;
  logic [32:0] span33, diff33;
  logic gt, gtq, full;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_DOMAIN_HIGH) ? {dh_q[30], dh_q} : {dl_q[30], dl_q};

  // ---------------- root range ----------------
  assign dl32   = {dl_q[30], dl_q};
  assign dh32   = {dh_q[30], dh_q};
  assign hi_eff = (dh32 < dl32) ? dl32 : dh32;
  assign span33 = {hi_eff[31], hi_eff} - {dl32[31], dl32};
  assign root_r = (span33 > SPAN) ? dl32 + SPAN[31:0] : hi_eff;

  assign seg_lo32 = {in_i.seg_lo[30], in_i.seg_lo};
  assign seg_hi32 = {in_i.seg_hi[30], in_i.seg_hi};
  assign clo = (seg_lo32 < dl32) ? dl32 : seg_lo32;
  assign chi = (seg_hi32 > root_r) ? root_r : seg_hi32;

  // ---------------- current node ----------------
  assign diff33 = {cr_q[31], cr_q} - {cl_q[31], cl_q};
  assign mid    = cl_q + diff33[32:1];
  assign full   = (lo_q <= cl_q) && (cr_q <= hi_q);

  // ---------------- shared evaluator ----------------
  always_comb begin
    ev_k = (state_q == ST_CA) ? nk_q : ck_q;
    ev_b = (state_q == ST_CA) ? nb_q : cb_q;
    case (ph_q)
      PH_M:    ev_x = mid;
      PH_L:    ev_x = cl_q;
      PH_R:    ev_x = cr_q;
      PH_Q:    ev_x = xq_q;
      default: ev_x = mid;
    endcase
  end

  slmt_eval_unit u_eval (
    .clk_i   (clk_i),
    .k_i     (ev_k),
    .b_i     (ev_b),
    .x_i     (ev_x),
    .value_o (ev_val)
  );

  assign gt  = $signed(va_q) > $signed(ev_val);
  assign gtq = $signed(res_q) > $signed(va_q);

  slmt_line_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (node_q),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.min_value = out_data_q;

  assign top_idx = SIW'(sp_q - SPW'(1));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q; ph_d = ph_q; node_d = node_q; clr_d = clr_q;
    cl_d = cl_q; cr_d = cr_q; lo_d = lo_q; hi_d = hi_q; xq_d = xq_q;
    ik_d = ik_q; ib_d = ib_q; ck_d = ck_q; cb_d = cb_q; nk_d = nk_q; nb_d = nb_q;
    va_d = va_q; res_d = res_q; first_d = first_q; sp_d = sp_q;
    dl_d = dl_q; dh_d = dh_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_data_d = out_data_q;
    mem_we = 1'b0; mem_waddr = node_q; mem_wdata = {ck_q, cb_q};
    push = 1'b0; push_node = {node_q[AW-2:0], 1'b1}; push_l = mid + 32'sd1;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {32'd0, EMPTY_VALUE};
        clr_d = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          node_d = AW'(1);
          cl_d = dl32;
          cr_d = root_r;
          if (in_i.mode == MODE_QUERY) begin
            xq_d = {in_i.query_x[30], in_i.query_x};
            first_d = 1'b1;
            ph_d = PH_Q;
            state_d = ST_RD;
          end else if ((seg_lo32 <= seg_hi32) && (clo <= chi)) begin
            lo_d = clo;
            hi_d = chi;
            ik_d = in_i.slope;
            ib_d = {{3{in_i.intercept[60]}}, in_i.intercept};
            sp_d = '0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (full) begin
          ck_d = ik_q;
          cb_d = ib_q;
          ph_d = PH_M;
          state_d = ST_RD;
        end else if (lo_q <= mid) begin
          // take the lower half now, leave the upper half for later
          if (hi_q > mid) push = 1'b1;
          node_d = {node_q[AW-2:0], 1'b0};
          cr_d = mid;
        end else begin
          node_d = {node_q[AW-2:0], 1'b1};
          cl_d = mid + 32'sd1;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          sp_d = sp_q - SPW'(1);
          node_d = stk_node_q[top_idx];
          cl_d = stk_l_q[top_idx];
          cr_d = stk_r_q[top_idx];
          state_d = ST_WALK;
        end
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        nk_d = mem_rdata[95:64];
        nb_d = mem_rdata[63:0];
        state_d = ST_CA;
      end
      ST_CA: state_d = ST_CB;
      ST_CB: state_d = ST_CW;
      ST_CW: begin
        va_d = ev_val;
        state_d = ST_CD;
      end
      ST_CD: begin
        case (ph_q)
          PH_Q: begin
            if (first_q || gtq) res_d = va_q;
            first_d = 1'b0;
            if (cl_q < cr_q) begin
              if (xq_q <= mid) begin
                node_d = {node_q[AW-2:0], 1'b0};
                cr_d = mid;
              end else begin
                node_d = {node_q[AW-2:0], 1'b1};
                cl_d = mid + 32'sd1;
              end
              state_d = ST_RD;
            end else begin
              state_d = ST_OUT;
            end
          end
          PH_M: begin
            if (gt) begin
              // carried line wins the node, old line goes on down
              mem_we = 1'b1;
              nk_d = ck_q; nb_d = cb_q;
              ck_d = nk_q; cb_d = nb_q;
            end
            if (cl_q == cr_q) begin
              state_d = ST_POP;
            end else begin
              ph_d = PH_L;
              state_d = ST_CA;
            end
          end
          PH_L: begin
            if (gt) begin
              node_d = {node_q[AW-2:0], 1'b0};
              cr_d = mid;
              ph_d = PH_M;
              state_d = ST_RD;
            end else begin
              ph_d = PH_R;
              state_d = ST_CA;
            end
          end
          PH_R: begin
            if (gt) begin
              node_d = {node_q[AW-2:0], 1'b1};
              cl_d = mid + 32'sd1;
              ph_d = PH_M;
              state_d = ST_RD;
            end else begin
              state_d = ST_POP;
            end
          end
          default: state_d = ST_POP;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push) sp_d = sp_q + SPW'(1);

    if (cfg_we) begin
      if (paddr[2] == REG_DOMAIN_HIGH) dh_d = pwdata[30:0];
      else dl_d = pwdata[30:0];
      clr_d = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ph_q <= PH_M;
      clr_q <= '0;
      sp_q <= '0;
      first_q <= 1'b0;
      dl_q <= 31'd0;
      dh_q <= 31'd1023;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      clr_q <= clr_d;
      sp_q <= sp_d;
      first_q <= first_d;
      dl_q <= dl_d;
      dh_q <= dh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d; cl_q <= cl_d; cr_q <= cr_d; lo_q <= lo_d; hi_q <= hi_d;
    xq_q <= xq_d; ik_q <= ik_d; ib_q <= ib_d; ck_q <= ck_d; cb_q <= cb_d;
    nk_q <= nk_d; nb_q <= nb_d; va_q <= va_d; res_q <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_node_q[sp_q[SIW-1:0]] <= push_node;
      stk_l_q[sp_q[SIW-1:0]] <= push_l;
      stk_r_q[sp_q[SIW-1:0]] <= cr_q;
    end
  end

  // ---------------- assertions ----------------
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STK_DEPTH))
    else $error("pending-node stack overflow");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("node store written while idle");

  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (node_q != '0))
    else $error("walk reached node zero");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CA) |-> (cl_q <= cr_q))
    else $error("node range inverted");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_line_min_tree: segment inserts and point
// minimum queries go in over valid/ready with random gaps and stalls. A
// software Li Chao tree predicts every query result, and results are compared
// in order. The domain registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import slmt_pkg::*;

  localparam int XB    = 10;
  localparam int NODES = 1 << (XB + 1);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors = 0;

  slmt_in_if  in_ch ();
  slmt_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  segment_line_min_tree #(.X_BITS(XB)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // software tree
  logic [31:0] tree_k[NODES];
  logic [63:0] tree_b[NODES];
  longint dom_lo = 0, dom_hi = 1023;
  logic [63:0] min_q[$];

  function automatic logic [63:0] line_y(logic [63:0] k, logic [63:0] b, longint x);
    return k * 64'(x) + b;
  endfunction

  function automatic bit above(logic [63:0] a, logic [63:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < NODES; i++) begin
      tree_k[i] = '0;
      tree_b[i] = EMPTY_VALUE;
    end
  endfunction

  function automatic void root_span(output longint l, output longint r);
    longint h;
    h = dom_hi;
    if (h < dom_lo) h = dom_lo;
    if (h - dom_lo > (64'sd1 << XB) - 1) h = dom_lo + (64'sd1 << XB) - 1;
    l = dom_lo;
    r = h;
  endfunction

  function automatic void add_line(int n, longint l, longint r, logic [63:0] k,
                                   logic [63:0] b, longint lo, longint hi);
    longint m;
    logic [63:0] ck, cb, t;
    if (hi < l || lo > r) return;
    n = n & (NODES - 1);
    m = l + ((r - l) >>> 1);
    if (lo <= l && r <= hi) begin
      ck = {{32{tree_k[n][31]}}, tree_k[n]};
      cb = tree_b[n];
      if (above(line_y(ck, cb, m), line_y(k, b, m))) begin
        t = ck; ck = k; k = t;
        t = cb; cb = b; b = t;
        tree_k[n] = ck[31:0];
        tree_b[n] = cb;
      end
      if (l == r) return;
      if (above(line_y(ck, cb, l), line_y(k, b, l)))
        add_line(2 * n, l, m, k, b, lo, hi);
      else if (above(line_y(ck, cb, r), line_y(k, b, r)))
        add_line(2 * n + 1, m + 1, r, k, b, lo, hi);
      return;
    end
    if (lo <= m) add_line(2 * n, l, m, k, b, lo, hi);
    if (hi > m) add_line(2 * n + 1, m + 1, r, k, b, lo, hi);
  endfunction

  function automatic logic [63:0] min_at(longint x);
    longint l, r, m;
    int n;
    logic [63:0] res, v;
    n = 1;
    root_span(l, r);
    res = line_y({{32{tree_k[1][31]}}, tree_k[1]}, tree_b[1], x);
    while (l < r) begin
      m = l + ((r - l) >>> 1);
      if (x <= m) begin
        n = 2 * n; r = m;
      end else begin
        n = 2 * n + 1; l = m + 1;
      end
      n = n & (NODES - 1);
      v = line_y({{32{tree_k[n][31]}}, tree_k[n]}, tree_b[n], x);
      if (above(res, v)) res = v;
    end
    return res;
  endfunction

  function automatic void predict(logic md, logic [31:0] k, logic [60:0] b,
                                  logic [30:0] slo, logic [30:0] shi,
                                  logic [30:0] qx);
    longint l, r, lo, hi;
    if (md == MODE_QUERY) begin
      min_q.push_back(min_at(longint'($signed(qx))));
      return;
    end
    lo = longint'($signed(slo));
    hi = longint'($signed(shi));
    if (lo > hi) return;
    root_span(l, r);
    if (lo < l) lo = l;
    if (hi > r) hi = r;
    if (lo > hi) return;
    add_line(1, l, r, {{32{k[31]}}, k}, {{3{b[60]}}, b}, lo, hi);
  endfunction

  // sender: valid stays up between back-to-back items, drops during a gap
  task automatic send_item(logic md, logic [31:0] k, logic [60:0] b,
                           logic [30:0] slo, logic [30:0] shi, logic [30:0] qx);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.slope <= k;
    in_ch.intercept <= b;
    in_ch.seg_lo <= slo;
    in_ch.seg_hi <= shi;
    in_ch.query_x <= qx;
    do @(posedge clk_i); while (!in_ch.ready);
    predict(md, k, b, slo, shi, qx);
  endtask

  // result checker and receiver stalls
  initial begin
    logic [63:0] exp_v;
    int stall;
    int wait_n;
    wait_n = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (min_q.size() == 0) begin
          $display("%0t: unexpected min_value %0d", $time, $signed(out_ch.min_value));
          errors++;
        end else begin
          exp_v = min_q.pop_front();
          if (out_ch.min_value !== exp_v) begin
            $display("%0t: min_value expected %0d actual %0d", $time,
                     $signed(exp_v), $signed(out_ch.min_value));
            errors++;
          end
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        wait_n = stall;
        out_ch.ready <= (stall == 0);
      end else if (!out_ch.ready) begin
        if (wait_n <= 1) begin
          out_ch.ready <= 1'b1;
        end else begin
          wait_n--;
        end
      end
    end
  end

  task automatic reg_write(logic idx, longint val);
    // wait until the block is idle so nothing is in flight
    do @(posedge clk_i); while (!in_ch.ready);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_DOMAIN_LOW) dom_lo = val;
    else dom_hi = val;
    wipe_tree();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (min_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_x(longint l, longint r);
    longint span;
    span = r - l;
    case ($urandom_range(0, 9))
      0: return 31'($urandom_range(0, 32'h7fffffff));
      1: return 31'(l - $urandom_range(0, 50));
      2: return 31'(r + $urandom_range(0, 50));
      default: return 31'(l + $urandom_range(0, 32'(span + 1 < 0 ? 0 : span)));
    endcase
  endfunction

  task automatic random_items(int count, int narrow);
    longint l, r;
    logic [31:0] k;
    logic [60:0] b;
    logic [30:0] a, c;
    root_span(l, r);
    for (int i = 0; i < count; i++) begin
      k = narrow ? 32'($signed($urandom_range(0, 2000)) - 1000) : $urandom();
      b = narrow ? 61'($signed($urandom_range(0, 2000000)) - 1000000)
                 : 61'({$urandom(), $urandom()});
      a = pick_x(l, r);
      c = pick_x(l, r);
      if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(c)) begin
        logic [30:0] t;
        t = a; a = c; c = t;
      end
      send_item(1'($urandom_range(0, 1)), k, b, a, c, pick_x(l, r));
    end
  endtask

  task automatic test_directed();
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd0);
    send_item(MODE_INSERT, 32'h7fffffff, 61'h0fff_ffff_ffff_ffff, 31'd0, 31'd1023, 31'd0);
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd1023);
    send_item(MODE_INSERT, 32'h80000000, 61'h1000_0000_0000_0000, 31'd0, 31'd1023, 31'd0);
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd0);
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd512);
    send_item(MODE_INSERT, 32'd5, 61'(-100), 31'd700, 31'd600, 31'd0);    // empty segment
    send_item(MODE_INSERT, 32'd5, 61'(-100), 31'(-900), 31'(-10), 31'd0); // outside domain
    send_item(MODE_INSERT, 32'(-3), 61'd20, 31'(-50), 31'd2000, 31'd0);   // clipped
    send_item(MODE_INSERT, 32'd1, 61'(-7), 31'd300, 31'd300, 31'd0);      // single point
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd300);
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'h40000000);      // far below domain
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'h3fffffff);      // far above domain
    send_item(MODE_QUERY, 32'd0, 61'd0, 31'd0, 31'd0, 31'd1024);
    drain();
  endtask

  task automatic test_domains();
    reg_write(REG_DOMAIN_LOW, -1000000000);
    reg_write(REG_DOMAIN_HIGH, 1000000000);            // wide, gets clamped
    random_items(200, 0);
    drain();
    reg_write(REG_DOMAIN_LOW, 1000000000);
    reg_write(REG_DOMAIN_HIGH, -1000000000);           // inverted domain
    random_items(100, 1);
    drain();
    reg_write(REG_DOMAIN_LOW, -37);
    reg_write(REG_DOMAIN_HIGH, 13);
    random_items(250, 1);
    drain();
  endtask

  task automatic test_random();
    reg_write(REG_DOMAIN_LOW, 0);
    reg_write(REG_DOMAIN_HIGH, 1023);
    random_items(500, 1);
    random_items(500, 0);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_INSERT;
    in_ch.slope = '0;
    in_ch.intercept = '0;
    in_ch.seg_lo = '0;
    in_ch.seg_hi = '0;
    in_ch.query_x = '0;
    wipe_tree();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_domains();
    test_random();
    repeat (400) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
